### hdl/point_gravity_acceleration_assert.svh
// Assertion macros for the point gravity acceleration block.
// Used by point_gravity_acceleration.sv; expects i_clk and i_rst_n in scope.
`ifndef POINT_GRAVITY_ACCELERATION_ASSERT_SVH
`define POINT_GRAVITY_ACCELERATION_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define PGA_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define PGA_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### hdl/pga_pkg.sv
// Shared types and constants for the point gravity acceleration block.
// No dependencies; used by the top level and pga_div_cell.
package pga_pkg;

    localparam int POS_FRAC_BITS_DEF = 8;
    localparam int POS_W             = 24;
    localparam int SIZE_W            = 20;
    localparam int CFG_DATA_W        = 16;
    localparam int CFG_IDX_W         = 2;
    localparam int LANES             = 2;
    localparam int MASS_FACTOR       = 20;
    localparam int MASS_SCALE_W      = 21;
    localparam int QUOT_W            = 32;
    localparam int ACC_FRAC_BITS     = 16;
    localparam int BUF_CNT_W         = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASS_COUNT = 2'd2;

    localparam logic [BUF_CNT_W-1:0] BUF_FULL = 2'd2;

    localparam logic [QUOT_W-1:0] ACC_POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [QUOT_W-1:0] ACC_NEG_LIMIT = 32'h8000_0000;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [SIZE_W-1:0]       body_width;
        logic [SIZE_W-1:0]       body_height;
    } t_in;

    typedef struct packed {
        logic signed [QUOT_W-1:0] accel_dx;
        logic signed [QUOT_W-1:0] accel_dy;
        logic                     at_center;
        logic                     saturated;
    } t_out;

    // Per-stage control that rides alongside the datapath.
    typedef struct packed {
        logic             valid;
        logic [LANES-1:0] neg;
        logic             at_center;
        logic [LANES-1:0] ovf;
    } t_ctl;

endpackage

### hdl/point_gravity_acceleration.sv
// Point gravity acceleration: top level, pipeline control and output buffer.
// Depends on pga_pkg, pga_sqrt_cell, pga_div_cell and the assertion header.
//
// Usage: an input transaction carries a body's corner position and size
// (POS_FRAC_BITS fraction bits). Each one yields exactly one result
// transaction with the x and y acceleration increments (16 fraction bits,
// saturated), an at_center flag and a saturated flag, in input order.
// Configuration: write center_x, center_y and mass_count through the plain
// write port while no transaction is in flight.
// Pipeline: between input acceptance and the output buffer lie ROOT_W root
// cells (ROOT_W = 27 at POS_FRAC_BITS = 8), 32 divider cells and eight
// arithmetic stages.
// Throughput: one transaction per cycle unless stalled; the chain of square
// root cells and divider cells advances when not held, each handling one bit.
// Stall: a two-entry output buffer absorbs the pipeline's last stage; when it
// is full the whole pipeline holds and o_in_stall rises. o_in_stall comes
// from a register only, not from i_out_stall.
// Reset (synchronous, active low) empties the pipeline and the buffer and
// sets all configuration registers to zero.
`include "point_gravity_acceleration_assert.svh"

module point_gravity_acceleration #(
    parameter int POS_FRAC_BITS = pga_pkg::POS_FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  pga_pkg::t_in                       i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output pga_pkg::t_out                      o_out_data,
    input  logic                               i_cfg_we,
    input  logic [pga_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pga_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int LN     = pga_pkg::LANES;
    localparam int QW     = pga_pkg::QUOT_W;
    localparam int CX_SPAN = pga_pkg::CFG_DATA_W + POS_FRAC_BITS;
    localparam int MAG_W  = ((CX_SPAN > pga_pkg::POS_W + 1) ? CX_SPAN
                                                            : pga_pkg::POS_W + 1) + 1;
    localparam int D_W    = MAG_W + 1;
    localparam int ROOT_W = MAG_W + 1;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int D2_W   = 2 * MAG_W + 1;
    localparam int RSQ_W  = 2 * ROOT_W;
    localparam int DEN_W  = 3 * ROOT_W;
    localparam int NUM_W  = pga_pkg::MASS_SCALE_W + MAG_W;
    localparam int SHIFT  = pga_pkg::ACC_FRAC_BITS + 2 * (POS_FRAC_BITS + 1);
    localparam int FULL_W = NUM_W + SHIFT;
    localparam int NHI_W  = FULL_W - QW;
    localparam int CMP_W  = (NHI_W > DEN_W) ? NHI_W : DEN_W;

    // configuration
    logic signed [pga_pkg::CFG_DATA_W-1:0] r_cx;
    logic signed [pga_pkg::CFG_DATA_W-1:0] r_cy;
    logic [pga_pkg::MASS_SCALE_W-1:0]      r_m20;

    // handshake and buffer
    logic                           w_adv;
    logic                           w_accept;
    logic                           w_push;
    logic                           w_pop;
    logic [pga_pkg::BUF_CNT_W-1:0]  r_cnt;
    logic [pga_pkg::BUF_CNT_W-1:0]  n_cnt;
    logic                           r_wr;
    logic                           r_rd;
    pga_pkg::t_out                  r_buf [2];

    // pipeline control
    pga_pkg::t_ctl r_a_ctl, r_b_ctl, r_c_ctl, r_d_ctl;
    pga_pkg::t_ctl r_e_ctl, r_g_ctl, r_h_ctl, r_i_ctl;
    pga_pkg::t_ctl n_b_ctl, n_i_ctl;
    pga_pkg::t_ctl r_s_ctl [ROOT_W];
    pga_pkg::t_ctl r_v_ctl [QW];

    // pipeline payload
    logic [LN-1:0][D_W-1:0]    n_a_d;
    logic [LN-1:0][D_W-1:0]    r_a_d;
    logic [LN-1:0][MAG_W-1:0]  n_b_mag;
    logic [LN-1:0][MAG_W-1:0]  r_b_mag;
    logic [LN-1:0][MAG_W-1:0]  r_c_mag;
    logic [LN-1:0][SQ_W-1:0]   r_c_sq;
    logic [LN-1:0][MAG_W-1:0]  r_d_mag;
    logic [D2_W-1:0]           r_d_d2;
    logic [LN-1:0][MAG_W-1:0]  r_s_mag [ROOT_W];
    logic [ROOT_W-1:0]         r_e_root;
    logic [RSQ_W-1:0]          r_e_sq;
    logic [LN-1:0][NUM_W-1:0]  r_e_num;
    logic [RSQ_W-1:0]          r_g_plo;
    logic [RSQ_W-1:0]          r_g_phi;
    logic [LN-1:0][NUM_W-1:0]  r_g_num;
    logic [DEN_W-1:0]          r_h_den;
    logic [LN-1:0][NUM_W-1:0]  r_h_num;
    logic [LN-1:0][FULL_W-1:0] w_i_full;
    logic [LN-1:0][CMP_W-1:0]  w_i_nhi;
    logic [LN-1:0]             w_i_ovf;
    logic [DEN_W-1:0]          r_i_den;
    logic [LN-1:0][DEN_W-1:0]  r_i_rem;
    logic [LN-1:0][QW-1:0]     r_i_low;

    // cell chains
    logic [D2_W-1:0]           w_rt_rem  [ROOT_W+1];
    logic [ROOT_W-1:0]         w_rt_root [ROOT_W+1];
    logic [DEN_W-1:0]          w_dv_den  [QW+1];
    logic [LN-1:0][DEN_W-1:0]  w_dv_rem  [QW+1];
    logic [LN-1:0][QW-1:0]     w_dv_low  [QW+1];
    logic [LN-1:0][QW-1:0]     w_dv_quot [QW+1];

    // result forming
    pga_pkg::t_ctl             w_o_ctl;
    logic [LN-1:0][QW-1:0]     w_lim;
    logic [LN-1:0]             w_clip;
    logic [LN-1:0][QW-1:0]     w_mag;
    logic [LN-1:0][QW-1:0]     w_acc;
    pga_pkg::t_out             w_res;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx  <= '0;
            r_cy  <= '0;
            r_m20 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pga_pkg::CFG_CENTER_X:   r_cx <= i_cfg_data;
                pga_pkg::CFG_CENTER_Y:   r_cy <= i_cfg_data;
                pga_pkg::CFG_MASS_COUNT: r_m20 <=
                    pga_pkg::MASS_SCALE_W'(i_cfg_data) *
                    pga_pkg::MASS_SCALE_W'(pga_pkg::MASS_FACTOR);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------- handshake
    assign w_adv      = (r_cnt != pga_pkg::BUF_FULL);
    assign w_accept   = i_in_valid && w_adv;
    assign o_in_stall = !w_adv;

    // ------------------------------------------------------ arithmetic comb
    // offset from body center to attractor, POS_FRAC_BITS+1 fraction bits
    assign n_a_d[0] = (D_W'(r_cx) << (POS_FRAC_BITS + 1))
                    - (D_W'(i_in_data.pos_x) << 1) - D_W'(i_in_data.body_width);
    assign n_a_d[1] = (D_W'(r_cy) << (POS_FRAC_BITS + 1))
                    - (D_W'(i_in_data.pos_y) << 1) - D_W'(i_in_data.body_height);

    always_comb begin
        n_b_ctl           = r_a_ctl;
        n_b_ctl.at_center = (r_a_d[0] == '0) && (r_a_d[1] == '0);
        n_b_ctl.ovf       = '0;
        for (int l = 0; l < LN; l++) begin
            n_b_ctl.neg[l] = r_a_d[l][D_W-1];
            n_b_mag[l]     = MAG_W'(r_a_d[l][D_W-1] ? (D_W'(0) - r_a_d[l]) : r_a_d[l]);
        end
    end

    for (genvar l = 0; l < LN; l++) begin : g_split
        assign w_i_full[l] = FULL_W'(r_h_num[l]) << SHIFT;
        assign w_i_nhi[l]  = CMP_W'(w_i_full[l][FULL_W-1:QW]);
        // quotient would need more than 32 bits
        assign w_i_ovf[l]  = w_i_nhi[l] >= CMP_W'(r_h_den);
    end

    always_comb begin
        n_i_ctl     = r_h_ctl;
        n_i_ctl.ovf = w_i_ovf;
    end

    // ---------------------------------------------------- pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
            r_b_ctl <= '0;
            r_c_ctl <= '0;
            r_d_ctl <= '0;
            r_e_ctl <= '0;
            r_g_ctl <= '0;
            r_h_ctl <= '0;
            r_i_ctl <= '0;
            for (int k = 0; k < ROOT_W; k++) r_s_ctl[k] <= '0;
            for (int k = 0; k < QW; k++) r_v_ctl[k] <= '0;
        end else if (w_adv) begin
            r_a_ctl       <= '0;
            r_a_ctl.valid <= w_accept;
            r_b_ctl       <= n_b_ctl;
            r_c_ctl       <= r_b_ctl;
            r_d_ctl       <= r_c_ctl;
            r_s_ctl[0]    <= r_d_ctl;
            for (int k = 1; k < ROOT_W; k++) r_s_ctl[k] <= r_s_ctl[k-1];
            r_e_ctl       <= r_s_ctl[ROOT_W-1];
            r_g_ctl       <= r_e_ctl;
            r_h_ctl       <= r_g_ctl;
            r_i_ctl       <= n_i_ctl;
            r_v_ctl[0]    <= r_i_ctl;
            for (int k = 1; k < QW; k++) r_v_ctl[k] <= r_v_ctl[k-1];
        end
    end

    // ---------------------------------------------------- pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_d    <= n_a_d;
            r_b_mag  <= n_b_mag;
            r_c_mag  <= r_b_mag;
            for (int l = 0; l < LN; l++) begin
                r_c_sq[l] <= SQ_W'(r_b_mag[l]) * SQ_W'(r_b_mag[l]);
            end
            r_d_mag  <= r_c_mag;
            r_d_d2   <= D2_W'(r_c_sq[0]) + D2_W'(r_c_sq[1]);
            r_s_mag[0] <= r_d_mag;
            for (int k = 1; k < ROOT_W; k++) r_s_mag[k] <= r_s_mag[k-1];
            r_e_root <= w_rt_root[ROOT_W];
            r_e_sq   <= RSQ_W'(w_rt_root[ROOT_W]) * RSQ_W'(w_rt_root[ROOT_W]);
            for (int l = 0; l < LN; l++) begin
                r_e_num[l] <= NUM_W'(r_m20) * NUM_W'(r_s_mag[ROOT_W-1][l]);
            end
            // r^3 as two partial products of r^2 by r
            r_g_plo  <= RSQ_W'(r_e_sq[ROOT_W-1:0]) * RSQ_W'(r_e_root);
            r_g_phi  <= RSQ_W'(r_e_sq[RSQ_W-1:ROOT_W]) * RSQ_W'(r_e_root);
            r_g_num  <= r_e_num;
            r_h_den  <= DEN_W'(r_g_plo) + (DEN_W'(r_g_phi) << ROOT_W);
            r_h_num  <= r_g_num;
            r_i_den  <= r_h_den;
            for (int l = 0; l < LN; l++) begin
                r_i_rem[l] <= w_i_nhi[l][DEN_W-1:0];
                r_i_low[l] <= w_i_full[l][QW-1:0];
            end
        end
    end

    // ------------------------------------------------------ square root row
    assign w_rt_rem[0]  = r_d_d2;
    assign w_rt_root[0] = '0;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_root
        pga_sqrt_cell #(
            .ROOT_W (ROOT_W),
            .REM_W  (D2_W),
            .BIT    (ROOT_W - 1 - k)
        ) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_rem  (w_rt_rem[k]),
            .i_root (w_rt_root[k]),
            .o_rem  (w_rt_rem[k+1]),
            .o_root (w_rt_root[k+1])
        );
    end

    // --------------------------------------------------------- divider row
    assign w_dv_den[0]  = r_i_den;
    assign w_dv_rem[0]  = r_i_rem;
    assign w_dv_low[0]  = r_i_low;
    assign w_dv_quot[0] = '0;

    for (genvar k = 0; k < QW; k++) begin : g_div
        pga_div_cell #(
            .DEN_W (DEN_W)
        ) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_den  (w_dv_den[k]),
            .i_rem  (w_dv_rem[k]),
            .i_low  (w_dv_low[k]),
            .i_quot (w_dv_quot[k]),
            .o_den  (w_dv_den[k+1]),
            .o_rem  (w_dv_rem[k+1]),
            .o_low  (w_dv_low[k+1]),
            .o_quot (w_dv_quot[k+1])
        );
    end

    // ------------------------------------------------ saturate and sign
    assign w_o_ctl = r_v_ctl[QW-1];

    always_comb begin
        for (int l = 0; l < LN; l++) begin
            w_lim[l]  = w_o_ctl.neg[l] ? pga_pkg::ACC_NEG_LIMIT : pga_pkg::ACC_POS_LIMIT;
            w_clip[l] = w_o_ctl.ovf[l] || (w_dv_quot[QW][l] > w_lim[l]);
            w_mag[l]  = w_clip[l] ? w_lim[l] : w_dv_quot[QW][l];
            w_acc[l]  = w_o_ctl.neg[l] ? (QW'(0) - w_mag[l]) : w_mag[l];
        end
        // zero distance: force zero, no clipping
        w_res.accel_dx  = w_o_ctl.at_center ? '0 : w_acc[0];
        w_res.accel_dy  = w_o_ctl.at_center ? '0 : w_acc[1];
        w_res.at_center = w_o_ctl.at_center;
        w_res.saturated = !w_o_ctl.at_center && (w_clip[0] || w_clip[1]);
    end

    // ------------------------------------------------------- output buffer
    assign w_push = w_adv && w_o_ctl.valid;
    assign w_pop  = (r_cnt != '0) && !i_out_stall;
    assign n_cnt  = r_cnt + pga_pkg::BUF_CNT_W'(w_push) - pga_pkg::BUF_CNT_W'(w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) r_wr <= !r_wr;
            if (w_pop)  r_rd <= !r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr] <= w_res;
        end
    end

    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = r_buf[r_rd];

    // ---------------------------------------------------------- assertions
    `PGA_ASSERT_HOLDS(a_buf_bound, r_cnt != 2'd3, "output buffer count out of range")
    `PGA_ASSERT_IMPLY(a_stall_needs_out, o_in_stall, o_out_valid,
        "input stalled while no result waits")
    `PGA_ASSERT_IMPLY(a_center_zero, o_out_valid && o_out_data.at_center,
        (o_out_data.accel_dx == '0) && (o_out_data.accel_dy == '0) && !o_out_data.saturated,
        "at_center result not zero")
    `PGA_ASSERT_IMPLY(a_sat_limit, o_out_valid && o_out_data.saturated,
        (o_out_data.accel_dx == pga_pkg::ACC_POS_LIMIT) ||
        (o_out_data.accel_dx == pga_pkg::ACC_NEG_LIMIT) ||
        (o_out_data.accel_dy == pga_pkg::ACC_POS_LIMIT) ||
        (o_out_data.accel_dy == pga_pkg::ACC_NEG_LIMIT),
        "saturated result holds no limit value")

endmodule

### hdl/pga_sqrt_cell.sv
// One bit of the pipelined integer square root: trial subtract and register.
// Depends on nothing but its parameters.
module pga_sqrt_cell #(
    parameter int ROOT_W = 27,
    parameter int REM_W  = 53,
    parameter int BIT    = 0
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [REM_W-1:0]  i_rem,
    input  logic [ROOT_W-1:0] i_root,
    output logic [REM_W-1:0]  o_rem,
    output logic [ROOT_W-1:0] o_root
);

    localparam int T_W = 2 * ROOT_W;

    logic [T_W-1:0]    w_trial;
    logic              w_take;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;

    // (root + 2^BIT)^2 - root^2; root has no bits at or below BIT yet
    assign w_trial = (T_W'(i_root) << (BIT + 1)) | (T_W'(1) << (2 * BIT));
    assign w_take  = T_W'(i_rem) >= w_trial;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= w_take ? REM_W'(T_W'(i_rem) - w_trial) : i_rem;
            r_root <= w_take ? (i_root | (ROOT_W'(1) << BIT)) : i_root;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

### hdl/pga_div_cell.sv
// One quotient bit of the pipelined restoring divider, both axes side by side.
// Depends on pga_pkg for lane count and quotient width.
module pga_div_cell #(
    parameter int DEN_W = 81
) (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic [DEN_W-1:0]                       i_den,
    input  logic [pga_pkg::LANES-1:0][DEN_W-1:0]   i_rem,
    input  logic [pga_pkg::LANES-1:0][pga_pkg::QUOT_W-1:0] i_low,
    input  logic [pga_pkg::LANES-1:0][pga_pkg::QUOT_W-1:0] i_quot,
    output logic [DEN_W-1:0]                       o_den,
    output logic [pga_pkg::LANES-1:0][DEN_W-1:0]   o_rem,
    output logic [pga_pkg::LANES-1:0][pga_pkg::QUOT_W-1:0] o_low,
    output logic [pga_pkg::LANES-1:0][pga_pkg::QUOT_W-1:0] o_quot
);

    localparam int T_W = DEN_W + 1;
    localparam int Q_W = pga_pkg::QUOT_W;

    logic [pga_pkg::LANES-1:0][T_W-1:0]   w_part;
    logic [pga_pkg::LANES-1:0]            w_take;
    logic [DEN_W-1:0]                     r_den;
    logic [pga_pkg::LANES-1:0][DEN_W-1:0] r_rem;
    logic [pga_pkg::LANES-1:0][Q_W-1:0]   r_low;
    logic [pga_pkg::LANES-1:0][Q_W-1:0]   r_quot;

    for (genvar l = 0; l < pga_pkg::LANES; l++) begin : g_lane
        // bring down the next dividend bit
        assign w_part[l] = {i_rem[l], i_low[l][Q_W-1]};
        assign w_take[l] = w_part[l] >= T_W'(i_den);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den <= i_den;
            for (int l = 0; l < pga_pkg::LANES; l++) begin
                r_rem[l]  <= w_take[l] ? DEN_W'(w_part[l] - T_W'(i_den))
                                       : w_part[l][DEN_W-1:0];
                r_low[l]  <= {i_low[l][Q_W-2:0], 1'b0};
                r_quot[l] <= {i_quot[l][Q_W-2:0], w_take[l]};
            end
        end
    end

    assign o_den  = r_den;
    assign o_rem  = r_rem;
    assign o_low  = r_low;
    assign o_quot = r_quot;

endmodule

### tb/tb_top.sv
// Self-checking bench for point_gravity_acceleration: drives random bodies and
// config settings, predicts every increment and compares it per field.
// Depends on pga_pkg and the block's RTL only.
module tb_top;

    localparam int FRAC_BITS   = 8;
    localparam int LATENCY     = 67;
    localparam int CYCLE_LIMIT = 600000;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_in_valid = 1'b0;
    logic          o_in_stall;
    pga_pkg::t_in  i_in_data = '0;
    logic          o_out_valid;
    logic          i_out_stall = 1'b0;
    pga_pkg::t_out o_out_data;
    logic          i_cfg_we = 1'b0;
    logic [pga_pkg::CFG_IDX_W-1:0]  i_cfg_idx = pga_pkg::CFG_CENTER_X;
    logic [pga_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    bit   calm = 1'b1;
    int   cycles = 0;

    always #6 i_clk = ~i_clk;

    point_gravity_acceleration dut (.*);

    class gravity_scoreboard;
        logic signed [15:0] cx, cy;
        logic [15:0]        mass;
        pga_pkg::t_out      accel_q[$];
        int                 errors;

        function new();
            cx = 0; cy = 0; mass = 0; errors = 0;
        endfunction

        function longint signed axis(longint signed d, logic [127:0] den, ref bit clip);
            longint unsigned mag;
            logic [127:0]    num, q, limit;
            mag   = d < 0 ? -d : d;
            limit = d < 0 ? 128'h8000_0000 : 128'h7FFF_FFFF;
            num   = 128'(64'(20) * 64'(mass) * mag) << (16 + 2 * (FRAC_BITS + 1));
            q     = num / den;
            if (q > limit) begin
                clip = 1'b1;
                q = limit;
            end
            return d < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
        endfunction

        function pga_pkg::t_out accel_of(pga_pkg::t_in v);
            longint signed   dx, dy, scale;
            longint unsigned ax, ay, r, c;
            logic [127:0]    d2, den;
            bit              clip;
            pga_pkg::t_out   o;
            scale = longint'(1) << (FRAC_BITS + 1);
            dx = longint'(cx) * scale - (2 * longint'(v.pos_x) + longint'(v.body_width));
            dy = longint'(cy) * scale - (2 * longint'(v.pos_y) + longint'(v.body_height));
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            o = '0;
            clip = 1'b0;
            if (ax == 0 && ay == 0) begin
                o.at_center = 1'b1;
                return o;
            end
            d2 = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
            r = 0;
            for (int b = 35; b >= 0; b--) begin
                c = r | (64'd1 << b);
                if (128'(c) * 128'(c) <= d2) r = c;
            end
            den = 128'(r) * 128'(r) * 128'(r);
            o.accel_dx  = 32'(axis(dx, den, clip));
            o.accel_dy  = 32'(axis(dy, den, clip));
            o.saturated = clip;
            return o;
        endfunction

        function void note_body(pga_pkg::t_in v);
            accel_q.push_back(accel_of(v));
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h want %h", what, got, want);
            errors++;
        endtask

        task check_accel(pga_pkg::t_out got);
            pga_pkg::t_out want;
            if (accel_q.size() == 0) begin
                report("unexpected transaction", got.accel_dx, 0);
                return;
            end
            want = accel_q.pop_front();
            if (got.accel_dx !== want.accel_dx) report("accel_dx", got.accel_dx, want.accel_dx);
            if (got.accel_dy !== want.accel_dy) report("accel_dy", got.accel_dy, want.accel_dy);
            if (got.at_center !== want.at_center)
                report("at_center", 32'(got.at_center), 32'(want.at_center));
            if (got.saturated !== want.saturated)
                report("saturated", 32'(got.saturated), 32'(want.saturated));
        endtask
    endclass

    gravity_scoreboard sb = new();

    // Observe both channels on the pre-edge values.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && i_in_valid && !o_in_stall) sb.note_body(i_in_data);
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_accel(o_out_data);
        i_out_stall <= calm ? 1'b0 : ($urandom_range(99) < 25);
        if (cycles > CYCLE_LIMIT) begin
            $display("point_gravity_acceleration verification failed");
            $finish;
        end
    end

    task send_body(pga_pkg::t_in v);
        while (!calm && $urandom_range(99) < 25) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= v;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Leave the write enable high; the caller drops it after the last write.
    task write_reg(logic [pga_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            pga_pkg::CFG_CENTER_X:   sb.cx = val;
            pga_pkg::CFG_CENTER_Y:   sb.cy = val;
            pga_pkg::CFG_MASS_COUNT: sb.mass = val;
            default: ;
        endcase
    endtask

    task drain;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.accel_q.size() != 0) @(posedge i_clk);
    endtask

    task set_attractor(logic [15:0] x, logic [15:0] y, logic [15:0] m);
        write_reg(pga_pkg::CFG_CENTER_X, x);
        write_reg(pga_pkg::CFG_CENTER_Y, y);
        write_reg(pga_pkg::CFG_MASS_COUNT, m);
        i_cfg_we <= 1'b0;
    endtask

    // Place one corner coordinate near, on, or far from the attractor axis.
    function void pick_axis(logic signed [15:0] ctr, int sel,
                            output logic [23:0] pos, output logic [19:0] size);
        longint signed p;
        int k;
        size = 20'($urandom);
        if (sel < 15) begin
            size = 20'($urandom_range(255)) << 1;
            p = longint'(ctr) * 256 - longint'(size) / 2;
            if (p < -(1 << 23) || p >= (1 << 23)) begin
                size = 0;
                p = longint'(ctr) * 256;
            end
            pos = 24'(p);
        end else if (sel < 65) begin
            k = $urandom_range(18);
            size = 20'($urandom_range(1 << ($urandom_range(12))));
            p = longint'(ctr) * 256 + (longint'($urandom) % (longint'(1) << k));
            if ($urandom_range(1)) p = longint'(ctr) * 256 - (p - longint'(ctr) * 256);
            pos = 24'(p);
        end else begin
            pos = 24'($urandom);
        end
    endfunction

    function pga_pkg::t_in random_body();
        pga_pkg::t_in v;
        int  sel;
        sel = $urandom_range(99);
        pick_axis(sb.cx, sel, v.pos_x, v.body_width);
        if (sel < 15 && $urandom_range(3) != 0) pick_axis(sb.cy, sel, v.pos_y, v.body_height);
        else pick_axis(sb.cy, $urandom_range(99), v.pos_y, v.body_height);
        return v;
    endfunction

    function pga_pkg::t_in body(int px, int py, int bw, int bh);
        pga_pkg::t_in v;
        v.pos_x = 24'(px);
        v.pos_y = 24'(py);
        v.body_width = 20'(bw);
        v.body_height = 20'(bh);
        return v;
    endfunction

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero mass, zero distance, field extremes, tiny offsets.
        send_body(body(0, 0, 0, 0));
        send_body(body(1, 0, 0, 0));
        drain();
        set_attractor(16'd0, 16'd0, 16'd65535);
        send_body(body(0, 0, 0, 0));
        send_body(body(-1, 0, 2, 0));
        send_body(body(-1, 0, 1, 0));
        send_body(body(0, -1, 0, 1));
        send_body(body(-1, -1, 1, 1));
        send_body(body(8388607, 0, 0, 0));
        send_body(body(-8388608, 0, 0, 0));
        send_body(body(0, 8388607, 0, 0));
        send_body(body(0, -8388608, 0, 0));
        send_body(body(8388607, 8388607, 1048575, 1048575));
        send_body(body(-8388608, -8388608, 0, 0));
        send_body(body(-8388608, -8388608, 1048575, 1048575));
        drain();
        set_attractor(16'h8000, 16'h7FFF, 16'd1);
        send_body(body(-8388608, 8388352, 0, 512));
        send_body(body(8388607, -8388608, 1048575, 0));
        send_body(body(-8388608, 8388607, 0, 0));
        send_body(body(0, 0, 0, 0));
        drain();
        set_attractor(16'h7FFF, 16'h8000, 16'd65535);
        send_body(body(8388352, -8388608, 512, 0));
        send_body(body(8388607, -8388608, 1048575, 1048575));
        send_body(body(-8388608, 8388607, 0, 0));

        for (int phase = 0; phase < 8; phase++) begin
            drain();
            case (phase)
                0:       set_attractor(16'd0, 16'd0, 16'd20);
                1:       set_attractor(16'h8000, 16'h8000, 16'd65535);
                2:       set_attractor(16'h7FFF, 16'h7FFF, 16'd0);
                default: set_attractor(16'($urandom), 16'($urandom), 16'($urandom));
            endcase
            for (int n = 0; n < 245; n++) begin
                calm = (phase == 3);
                send_body(random_body());
            end
        end
        calm = 1'b0;
        drain();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("point_gravity_acceleration verification clean");
        end else begin
            $display("point_gravity_acceleration verification failed");
        end
        $finish;
    end
endmodule
